>>> design/rc4_pkg.sv
// rc4 cipher core package: byte types, opcodes, register widths and the sbox port bundle
// no dependencies; used by the interfaces, the memories and the top level
`default_nettype none

package rc4_pkg;

    typedef logic [7:0] t_byte;

    // configuration register width and reset value
    localparam int unsigned LEN_W = 9;
    typedef logic [LEN_W-1:0] t_len;
    localparam t_len KEY_LEN_RESET = t_len'(16);

    // operation codes carried by an input transfer
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_LOAD_KEY = 2'd0;
    localparam t_opcode OP_SCHEDULE = 2'd1;
    localparam t_opcode OP_CRYPT    = 2'd2;

    // one write and one read request to the sbox memory in a cycle
    typedef struct packed {
        logic  we;
        t_byte waddr;
        t_byte wdata;
        logic  re;
        t_byte raddr;
    } t_sbox_req;

endpackage

`default_nettype wire

>>> design/rc4_if.sv
// valid/ready channel interfaces of the rc4 cipher core: data in, result out, configuration
// depends on rc4_pkg
`default_nettype none

interface rc4_in_if;
    logic              valid;
    logic              ready;
    rc4_pkg::t_opcode  opcode;
    rc4_pkg::t_byte    key_index;
    rc4_pkg::t_byte    key_byte;
    rc4_pkg::t_byte    data_in;

    modport source (output valid, output opcode, output key_index, output key_byte,
                    output data_in, input ready);
    modport sink   (input valid, input opcode, input key_index, input key_byte,
                    input data_in, output ready);
endinterface

interface rc4_out_if;
    logic            valid;
    logic            ready;
    rc4_pkg::t_byte  data_out;
    rc4_pkg::t_byte  key_stream;
    logic            keyed;

    modport source (output valid, output data_out, output key_stream, output keyed,
                    input ready);
    modport sink   (input valid, input data_out, input key_stream, input keyed,
                    output ready);
endinterface

interface rc4_cfg_if;
    logic           valid;
    logic           ready;
    rc4_pkg::t_len  wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

`default_nettype wire

>>> design/rc4_key_mem.sv
// key byte store: one write port, one read port with registered read data
// depends on rc4_pkg
`default_nettype none

module rc4_key_mem #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire rc4_pkg::t_byte                               i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output rc4_pkg::t_byte                                    o_rdata
);

    rc4_pkg::t_byte r_mem [DEPTH];
    rc4_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rc4_sbox_mem.sv
// 256-entry permutation memory: one write and one read a cycle, registered read data
// a read of the entry being written in the same cycle returns the new value; depends on rc4_pkg
`default_nettype none

module rc4_sbox_mem (
    input  wire logic               i_clk,
    input  wire rc4_pkg::t_sbox_req i_req,
    output rc4_pkg::t_byte          o_rdata
);

    rc4_pkg::t_byte r_mem [256];
    rc4_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            if (i_req.we && (i_req.waddr == i_req.raddr)) begin
                r_rdata <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rc4_stream_cipher_core.sv
// rc4 cipher core. key byte load: stored when accepted, if its index is below MAX_KEY_LEN.
// key schedule: busy for 256 identity writes, then 256 swap steps (states KB, KC, KD).
// keyed crypt byte: the transfer reads S[i], PB reads S[j], PC writes S[i] and reads S[t],
// PD writes S[j] and loads the output register once it is free, and may take the next byte.
// unkeyed crypt byte: result offered the cycle after the transfer. reset clears control
// state, indices and keyed flag and sets key length to 16; sbox and key store are not cleared.
`default_nettype none

module rc4_stream_cipher_core #(
    parameter int unsigned MAX_KEY_LEN = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rc4_in_if.sink      i_data_chan,
    rc4_out_if.source   o_result_chan,
    rc4_cfg_if.sink     i_cfg_chan
);

    localparam int unsigned KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int unsigned LW  = rc4_pkg::LEN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_KB   = 3'd2;
    localparam logic [2:0] ST_KC   = 3'd3;
    localparam logic [2:0] ST_KD   = 3'd4;
    localparam logic [2:0] ST_PB   = 3'd5;
    localparam logic [2:0] ST_PC   = 3'd6;
    localparam logic [2:0] ST_PD   = 3'd7;

    logic [2:0]        r_state, n_state;
    rc4_pkg::t_byte    r_i, n_i;
    rc4_pkg::t_byte    r_j, n_j;
    logic [KAW-1:0]    r_k, n_k;
    rc4_pkg::t_len     r_len, n_len;
    rc4_pkg::t_byte    r_si, n_si;
    logic              r_t_hit, n_t_hit;
    rc4_pkg::t_byte    r_data, n_data;
    logic              r_keyed, n_keyed;
    rc4_pkg::t_len     r_key_len;

    logic              r_out_valid;
    rc4_pkg::t_byte    r_out_data;
    rc4_pkg::t_byte    r_out_ks;
    logic              r_out_keyed;

    logic               w_acc;
    logic               w_out_free;
    logic               w_out_load;
    rc4_pkg::t_byte     w_out_data;
    rc4_pkg::t_byte     w_out_ks;
    logic               w_out_keyed;
    rc4_pkg::t_sbox_req w_req;
    rc4_pkg::t_byte     w_sbox_rdata;
    rc4_pkg::t_byte     w_key_rdata;
    logic [KAW-1:0]     w_key_raddr;
    logic               w_key_we;
    logic [LW-1:0]      w_k_inc;
    logic [KAW-1:0]     w_k_next;
    rc4_pkg::t_len      w_eff_len;
    rc4_pkg::t_byte     w_jn;
    rc4_pkg::t_byte     w_t;
    rc4_pkg::t_byte     w_ks;

    assign w_out_free        = !r_out_valid || o_result_chan.ready;
    assign i_data_chan.ready = ((r_state == ST_IDLE) || (r_state == ST_PD)) && w_out_free;
    assign w_acc             = i_data_chan.valid && i_data_chan.ready;
    assign i_cfg_chan.ready  = 1'b1;

    // key bytes past the store depth are never read by a schedule
    assign w_key_we = w_acc && (i_data_chan.opcode == rc4_pkg::OP_LOAD_KEY)
                      && (LW'(i_data_chan.key_index) < LW'(MAX_KEY_LEN));

    // cyclic key position
    assign w_k_inc  = LW'(r_k) + LW'(1);
    assign w_k_next = (w_k_inc >= r_len) ? '0 : w_k_inc[KAW-1:0];

    always_comb begin
        if (r_key_len == '0) begin
            w_eff_len = rc4_pkg::t_len'(1);
        end else if (r_key_len > LW'(MAX_KEY_LEN)) begin
            w_eff_len = LW'(MAX_KEY_LEN);
        end else begin
            w_eff_len = r_key_len;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_len       = r_len;
        n_si        = r_si;
        n_t_hit     = r_t_hit;
        n_data      = r_data;
        n_keyed     = r_keyed;
        w_req       = '0;
        w_key_raddr = '0;
        w_out_load  = 1'b0;
        w_out_data  = r_data;
        w_out_ks    = '0;
        w_out_keyed = r_keyed;
        w_jn        = r_j + w_sbox_rdata;
        w_t         = r_si + w_sbox_rdata;
        w_ks        = r_t_hit ? r_si : w_sbox_rdata;

        case (r_state)
            ST_IDLE: begin
            end
            ST_FILL: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_i;
                w_req.wdata = r_i;
                n_i         = r_i + 8'd1;
                if (r_i == 8'hFF) begin
                    // first swap step reads S[0] and key[0]
                    w_req.re    = 1'b1;
                    w_req.raddr = r_i + 8'd1;
                    n_k         = '0;
                    n_j         = '0;
                    n_state     = ST_KB;
                end
            end
            ST_KB: begin
                w_jn        = r_j + w_sbox_rdata + w_key_rdata;
                n_j         = w_jn;
                n_si        = w_sbox_rdata;
                w_req.re    = 1'b1;
                w_req.raddr = w_jn;
                n_state     = ST_KC;
            end
            ST_KC: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_i;
                w_req.wdata = w_sbox_rdata;
                n_state     = ST_KD;
            end
            ST_KD: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_si;
                n_i         = r_i + 8'd1;
                if (r_i == 8'hFF) begin
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    // next step's reads overlap this write
                    w_req.re    = 1'b1;
                    w_req.raddr = r_i + 8'd1;
                    w_key_raddr = w_k_next;
                    n_k         = w_k_next;
                    n_state     = ST_KB;
                end
            end
            ST_PB: begin
                n_j         = w_jn;
                n_si        = w_sbox_rdata;
                w_req.re    = 1'b1;
                w_req.raddr = w_jn;
                n_state     = ST_PC;
            end
            ST_PC: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_i;
                w_req.wdata = w_sbox_rdata;
                w_req.re    = 1'b1;
                w_req.raddr = w_t;
                // S[j] is written only next cycle, so its new value comes from r_si
                n_t_hit     = (w_t == r_j);
                n_state     = ST_PD;
            end
            ST_PD: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_si;
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    w_out_ks    = w_ks;
                    w_out_data  = r_data ^ w_ks;
                    w_out_keyed = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_acc) begin
            case (i_data_chan.opcode)
                rc4_pkg::OP_SCHEDULE: begin
                    n_i     = '0;
                    n_len   = w_eff_len;
                    n_state = ST_FILL;
                end
                rc4_pkg::OP_CRYPT: begin
                    if (r_keyed) begin
                        w_req.re    = 1'b1;
                        w_req.raddr = r_i + 8'd1;
                        n_i         = r_i + 8'd1;
                        n_data      = i_data_chan.data_in;
                        n_state     = ST_PB;
                    end else begin
                        w_out_load  = 1'b1;
                        w_out_data  = i_data_chan.data_in;
                        w_out_ks    = '0;
                        w_out_keyed = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_len   <= rc4_pkg::KEY_LEN_RESET;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_keyed <= n_keyed;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result_chan.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_chan.valid && i_cfg_chan.ready) begin
                r_key_len <= i_cfg_chan.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_len   <= n_len;
        r_si    <= n_si;
        r_t_hit <= n_t_hit;
        r_data  <= n_data;
        if (w_out_load) begin
            r_out_data  <= w_out_data;
            r_out_ks    <= w_out_ks;
            r_out_keyed <= w_out_keyed;
        end
    end

    assign o_result_chan.valid      = r_out_valid;
    assign o_result_chan.data_out   = r_out_data;
    assign o_result_chan.key_stream = r_out_ks;
    assign o_result_chan.keyed      = r_out_keyed;

    rc4_sbox_mem u_sbox (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_sbox_rdata)
    );

    rc4_key_mem #(
        .DEPTH (MAX_KEY_LEN)
    ) u_key (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (i_data_chan.key_index[KAW-1:0]),
        .i_wdata (i_data_chan.key_byte),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rdata)
    );

    // an unkeyed result never carries keystream
    a_unkeyed_zero_ks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_keyed) |-> (r_out_ks == '0))
        else $error("unkeyed result with non-zero keystream");

    // keyed only comes up at the final swap step
    a_keyed_from_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_keyed && !$past(r_keyed)) |-> ($past(r_state) == ST_KD))
        else $error("keyed set outside the key schedule");

    // the schedule leaves both generator indices at zero
    a_sched_clears_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KD && r_i == 8'hFF) |=> (r_i == '0 && r_j == '0
            && r_state == ST_IDLE))
        else $error("indices not cleared after key schedule");

endmodule

`default_nettype wire
